>>> rtl/segregated_free_list_bin_repair_unit_assert.svh
// Assertion macros for the bin repair unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SEGREGATED_FREE_LIST_BIN_REPAIR_UNIT_ASSERT_SVH
`define SEGREGATED_FREE_LIST_BIN_REPAIR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFL_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SFL_ASSERT(lbl, prop, msg)
`define SFL_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/sfl_pkg.sv
// Shared constants, codes and helper functions of the bin repair unit.
// No dependencies.
package sfl_pkg;
    localparam int NODES_DEF           = 256;
    localparam int SIZE_BITS_DEF       = 24;
    localparam int MIN_BLOCK_BYTES_DEF = 16;

    localparam int LINK_W      = 9;
    localparam int BIN_W       = 4;
    localparam int REQ_W       = 16;
    localparam int BIN_COUNT   = 9;
    localparam logic [BIN_W-1:0] TOP_BIN = 4'd8;
    localparam logic [REQ_W-1:0] SMALL_LIMIT = 16'hFE7B;
    localparam logic [LINK_W-1:0] NONE_CODE = 9'd256;
    localparam logic [31:0] BEST_INIT = 32'h7FFF_FFFF;
    localparam int TOL_INIT    = 16;
    localparam int TOL_STEP    = 4;
    localparam int HDR_BYTES   = 8;
    localparam int GUARD_BYTES = 2;
    localparam int ALIGN_ADD   = 7;

    localparam logic [1:0] CMD_NODE = 2'd0;
    localparam logic [1:0] CMD_HEAD = 2'd1;
    localparam logic [1:0] CMD_REQ  = 2'd2;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_DEBUG   = 2'd1;
    localparam logic [1:0] CFG_PROTECT = 2'd2;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;

    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_BYPASS   = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FIT      = 3'd3,
        ST_PROMOTED = 3'd4,
        ST_NOFIT    = 3'd5
    } status_t;

    function automatic logic [BIN_W-1:0] bin_of(input logic [31:0] size);
        logic [26:0] b;
        b = size[31:5];
        bin_of = (b < 27'(TOP_BIN)) ? b[BIN_W-1:0] : TOP_BIN;
    endfunction
endpackage

>>> rtl/sfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sfl_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/segregated_free_list_bin_repair_unit.sv
// Top level of the segregated free-list bin repair unit: sequencer and bin heads.
// Depends on sfl_pkg, sfl_ram and the assertion macro header.
//
//  Channel  | Handshake        | Beat
//  ---------+------------------+---------------------------------------------
//  command  | start && !busy   | command, node, head and request fields
//  result   | done (one cycle) | status, promoted_node, source_bin, target, req
//  config   | cfg_we           | cfg_index, cfg_data
//
// Node and head writes are done from idle and leave busy low.
// A request reads its nodes one at a time through the single node RAM read port,
// walking the target bin, then scanning higher bins, and may end in an unlink.
// Reset clears the bin heads and the state, config and done registers at once; no clearing pass is needed.
// The receiver cannot stall: each result beat is shown for one cycle.
module segregated_free_list_bin_repair_unit #(
    parameter int NODES           = sfl_pkg::NODES_DEF,
    parameter int SIZE_BITS       = sfl_pkg::SIZE_BITS_DEF,
    parameter int MIN_BLOCK_BYTES = sfl_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [7:0]            node_index,
    input  logic [SIZE_BITS-1:0]  node_size,
    input  logic [8:0]            node_link,
    input  logic                  node_free,
    input  logic [3:0]            bin_number,
    input  logic [8:0]            head_index,
    input  logic [15:0]           requested_bytes,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [1:0]            cfg_data,
    output logic                  done,
    output logic [2:0]            status,
    output logic [8:0]            promoted_node,
    output logic [3:0]            source_bin,
    output logic [3:0]            target_bin,
    output logic [15:0]           required_bytes
);
    import sfl_pkg::*;
    `include "segregated_free_list_bin_repair_unit_assert.svh"

    localparam int AW    = $clog2(NODES);
    localparam int EW    = SIZE_BITS + LINK_W + 1;
    localparam int VIS_W = AW + 1;
    localparam int TOL_W = AW + 4;
    localparam logic [31:0] NODES_W = 32'(NODES);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HEAD = 7'b0000010,
        S_WALK = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_UNL1 = 7'b0010000,
        S_UNL2 = 7'b0100000,
        S_UNL3 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] mode_reg;
    logic debug_reg, protect_reg;
    logic [LINK_W-1:0] heads_reg [BIN_COUNT];

    logic [AW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic prev_valid_reg, prev_valid_next;
    logic [AW-1:0] best_node_reg, best_node_next, best_prev_reg, best_prev_next;
    logic best_valid_reg, best_valid_next, best_prev_valid_reg, best_prev_valid_next;
    logic [31:0] best_reg, best_next;
    logic [TOL_W-1:0] tol_reg, tol_next;
    logic [VIS_W-1:0] visited_reg, visited_next;
    logic [BIN_W-1:0] walk_bin_reg, walk_bin_next, b_reg, b_next;
    logic phase_reg, phase_next;
    logic [BIN_W-1:0] target_reg, target_next;
    logic [REQ_W-1:0] required_reg, required_next;
    logic [SIZE_BITS-1:0] n_size_reg, n_size_next;
    logic [LINK_W-1:0] n_link_reg, n_link_next;
    logic n_free_reg, n_free_next;

    logic done_reg, done_next;
    logic [2:0] status_reg, status_next;
    logic [8:0] pnode_reg, pnode_next;
    logic [3:0] src_reg, src_next, tgt_reg, tgt_next;
    logic [15:0] req_reg, req_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic head_we;
    logic [BIN_W-1:0] head_waddr, head_rsel;
    logic [LINK_W-1:0] head_wdata, head_rd;

    logic [SIZE_BITS-1:0] r_size;
    logic [LINK_W-1:0] r_link;
    logic r_free, r_plaus, r_end, r_fit;
    logic [31:0] r_rem;
    logic [16:0] req_sum;
    logic [REQ_W-1:0] req_c;
    logic [BIN_W-1:0] tgt_c;
    logic stop_c;

    sfl_ram #(.WIDTH(EW), .DEPTH(NODES)) u_nodes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_size  = ram_rdata[SIZE_BITS-1:0];
    assign r_link  = ram_rdata[SIZE_BITS+LINK_W-1:SIZE_BITS];
    assign r_free  = ram_rdata[EW-1];
    assign r_plaus = r_free && (r_size[2:0] == 3'd0) &&
                     (32'(r_size) >= 32'(MIN_BLOCK_BYTES));
    assign r_end   = (32'(r_link) >= NODES_W);
    assign r_fit   = (32'(r_size) >= 32'(required_reg));
    assign r_rem   = 32'(r_size) - 32'(required_reg);

    assign req_sum = 17'(requested_bytes) + 17'(HDR_BYTES + ALIGN_ADD) +
                     (debug_reg ? 17'(GUARD_BYTES) : 17'd0);
    assign req_c   = req_sum[15:0] & ~16'd7;
    assign tgt_c   = bin_of(32'(req_c));
    assign head_rd = heads_reg[head_rsel];

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        prev_valid_next = prev_valid_reg;
        best_node_next = best_node_reg;
        best_prev_next = best_prev_reg;
        best_valid_next = best_valid_reg;
        best_prev_valid_next = best_prev_valid_reg;
        best_next = best_reg;
        tol_next = tol_reg;
        visited_next = visited_reg;
        walk_bin_next = walk_bin_reg;
        b_next = b_reg;
        phase_next = phase_reg;
        target_next = target_reg;
        required_next = required_reg;
        n_size_next = n_size_reg;
        n_link_next = n_link_reg;
        n_free_next = n_free_reg;
        done_next = 1'b0;
        status_next = status_reg;
        pnode_next = pnode_reg;
        src_next = src_reg;
        tgt_next = tgt_reg;
        req_next = req_reg;
        ram_we = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = {n_free_reg, n_link_reg, n_size_reg};
        ram_raddr = cur_reg;
        head_we = 1'b0;
        head_waddr = b_reg;
        head_wdata = n_link_reg;
        head_rsel = target_reg;
        stop_c = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                head_rsel = tgt_c;
                if (start)
                begin
                    done_next = 1'b1;
                    status_next = ST_ACK;
                    pnode_next = NONE_CODE;
                    src_next = '0;
                    tgt_next = '0;
                    req_next = '0;
                    unique case (command)
                        CMD_NODE:
                        begin
                            if (32'(node_index) < NODES_W)
                            begin
                                ram_we = 1'b1;
                                ram_waddr = AW'(node_index);
                                ram_wdata = {node_free, node_link, node_size};
                            end
                        end
                        CMD_HEAD:
                        begin
                            if (32'(bin_number) < 32'(BIN_COUNT))
                            begin
                                head_we = 1'b1;
                                head_waddr = bin_number;
                                head_wdata = head_index;
                            end
                        end
                        CMD_REQ:
                        begin
                            if (requested_bytes > SMALL_LIMIT)
                            begin
                                status_next = ST_BYPASS;
                            end
                            else
                            begin
                                tgt_next = tgt_c;
                                req_next = req_c;
                                target_next = tgt_c;
                                required_next = req_c;
                                if (mode_reg == MODE_OFF || protect_reg ||
                                    32'(head_rd) >= NODES_W)
                                begin
                                    status_next = ST_BYPASS;
                                end
                                else
                                begin
                                    done_next = 1'b0;
                                    cur_next = AW'(head_rd);
                                    ram_raddr = AW'(head_rd);
                                    state_next = S_HEAD;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (!r_plaus || bin_of(32'(r_size)) != target_reg)
                begin
                    done_next = 1'b1;
                    status_next = ST_INVALID;
                    state_next = S_IDLE;
                end
                else if (r_fit || (target_reg == TOP_BIN && mode_reg == MODE_SEARCH))
                begin
                    done_next = 1'b1;
                    status_next = ST_BYPASS;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_valid_next = 1'b0;
                    best_valid_next = 1'b0;
                    best_next = BEST_INIT;
                    tol_next = TOL_W'(TOL_INIT);
                    visited_next = '0;
                    walk_bin_next = target_reg;
                    phase_next = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (visited_reg >= VIS_W'(NODES) || !r_plaus ||
                    bin_of(32'(r_size)) != walk_bin_reg)
                begin
                    done_next = 1'b1;
                    status_next = ST_INVALID;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (r_fit && r_rem < best_reg)
                    begin
                        best_node_next = cur_reg;
                        best_prev_next = prev_reg;
                        best_prev_valid_next = prev_valid_reg;
                        best_valid_next = 1'b1;
                        best_next = r_rem;
                        if (r_rem < 32'(tol_reg))
                        begin
                            stop_c = 1'b1;
                        end
                        else
                        begin
                            tol_next = tol_reg + TOL_W'(TOL_STEP);
                        end
                    end
                    if (!stop_c && !r_end)
                    begin
                        prev_next = cur_reg;
                        prev_valid_next = 1'b1;
                        cur_next = AW'(r_link);
                        ram_raddr = AW'(r_link);
                        visited_next = visited_reg + VIS_W'(1);
                    end
                    else if (!phase_reg)
                    begin
                        if (best_valid_next)
                        begin
                            done_next = 1'b1;
                            status_next = ST_FIT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            b_next = target_reg + BIN_W'(1);
                            state_next = S_SCAN;
                        end
                    end
                    else if (best_valid_next)
                    begin
                        ram_raddr = best_node_next;
                        state_next = S_UNL1;
                    end
                    else
                    begin
                        b_next = b_reg + BIN_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                head_rsel = (32'(b_reg) < 32'(BIN_COUNT)) ? b_reg : '0;
                if (32'(b_reg) >= 32'(BIN_COUNT))
                begin
                    done_next = 1'b1;
                    status_next = ST_NOFIT;
                    state_next = S_IDLE;
                end
                else if (32'(head_rd) >= NODES_W)
                begin
                    b_next = b_reg + BIN_W'(1);
                end
                else
                begin
                    cur_next = AW'(head_rd);
                    ram_raddr = AW'(head_rd);
                    prev_valid_next = 1'b0;
                    best_valid_next = 1'b0;
                    best_next = BEST_INIT;
                    tol_next = TOL_W'(TOL_INIT);
                    visited_next = '0;
                    walk_bin_next = b_reg;
                    phase_next = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_UNL1:
            begin
                n_size_next = r_size;
                n_link_next = r_link;
                n_free_next = r_free;
                if (!best_prev_valid_reg)
                begin
                    head_we = 1'b1;
                    head_waddr = b_reg;
                    head_wdata = r_link;
                    state_next = S_UNL3;
                end
                else
                begin
                    ram_raddr = best_prev_reg;
                    state_next = S_UNL2;
                end
            end
            S_UNL2:
            begin
                ram_we = 1'b1;
                ram_waddr = best_prev_reg;
                ram_wdata = {r_free, n_link_reg, r_size};
                state_next = S_UNL3;
            end
            S_UNL3:
            begin
                head_rsel = target_reg;
                ram_we = 1'b1;
                ram_waddr = best_node_reg;
                ram_wdata = {n_free_reg, head_rd, n_size_reg};
                head_we = 1'b1;
                head_waddr = target_reg;
                head_wdata = LINK_W'(best_node_reg);
                done_next = 1'b1;
                status_next = ST_PROMOTED;
                pnode_next = 9'(best_node_reg);
                src_next = b_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= MODE_OFF;
            debug_reg <= 1'b0;
            protect_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                heads_reg[i] <= NONE_CODE;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            if (head_we)
            begin
                heads_reg[head_waddr] <= head_wdata;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:    mode_reg <= cfg_data;
                    CFG_DEBUG:   debug_reg <= cfg_data[0];
                    CFG_PROTECT: protect_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        prev_valid_reg <= prev_valid_next;
        best_node_reg <= best_node_next;
        best_prev_reg <= best_prev_next;
        best_valid_reg <= best_valid_next;
        best_prev_valid_reg <= best_prev_valid_next;
        best_reg <= best_next;
        tol_reg <= tol_next;
        visited_reg <= visited_next;
        walk_bin_reg <= walk_bin_next;
        b_reg <= b_next;
        phase_reg <= phase_next;
        target_reg <= target_next;
        required_reg <= required_next;
        n_size_reg <= n_size_next;
        n_link_reg <= n_link_next;
        n_free_reg <= n_free_next;
        status_reg <= status_next;
        pnode_reg <= pnode_next;
        src_reg <= src_next;
        tgt_reg <= tgt_next;
        req_reg <= req_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
    assign promoted_node = pnode_reg;
    assign source_bin = src_reg;
    assign target_bin = tgt_reg;
    assign required_bytes = req_reg;

    // A walk never writes the node store, so reads cannot see a stale entry.
    `SFL_NEVER(a_no_write_in_walk, (state_reg == S_WALK) && ram_we, "node write during walk")
    `SFL_ASSERT(a_visit_bound, (state_reg == S_WALK) |-> (visited_reg <= VIS_W'(NODES)), "walk overran")
    `SFL_ASSERT(a_promote_result, (state_reg == S_UNL3) |=> (done && status == ST_PROMOTED), "promotion lost")
    `SFL_ASSERT(a_scan_above_target, (state_reg == S_SCAN) |-> (b_reg > target_reg), "scan below target")
endmodule

>>> verif/tb_top.sv
// Self-checking testbench for segregated_free_list_bin_repair_unit: directed table, then random
// phases of node writes, head writes, allocation requests and invalid commands checked against a local model.
// Depends on sfl_pkg and the unit's RTL.
module tb_top;
    import sfl_pkg::*;

    localparam int        NODE_COUNT    = 256;
    localparam int        CYCLE_LIMIT   = 50_000_000;
    localparam int        SETTLE_CYCLES = 300;
    localparam logic [1:0] CMD_BAD       = 2'd3;
    localparam logic [1:0] MODE_COALESCE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [23:0] size;
        logic [8:0]  link;
        logic        free;
        logic [3:0]  bin;
        logic [8:0]  head;
        logic [15:0] reqb;
    } beat_t;

    typedef struct packed {
        status_t     st;
        logic [8:0]  node;
        logic [3:0]  src;
        logic [3:0]  tgt;
        logic [15:0] req;
    } outcome_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_idx;
        logic [1:0] cfg_val;
        beat_t      b;
        bit         typed;
        outcome_t   want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  command = '0;
    logic [7:0]  node_index = '0;
    logic [23:0] node_size = '0;
    logic [8:0]  node_link = '0;
    logic        node_free = 1'b0;
    logic [3:0]  bin_number = '0;
    logic [8:0]  head_index = '0;
    logic [15:0] requested_bytes = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [1:0]  cfg_data = '0;
    logic        busy, done;
    logic [2:0]  status;
    logic [8:0]  promoted_node;
    logic [3:0]  source_bin, target_bin;
    logic [15:0] required_bytes;

    segregated_free_list_bin_repair_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .node_index(node_index), .node_size(node_size), .node_link(node_link),
        .node_free(node_free), .bin_number(bin_number), .head_index(head_index),
        .requested_bytes(requested_bytes), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .status(status), .promoted_node(promoted_node),
        .source_bin(source_bin), .target_bin(target_bin), .required_bytes(required_bytes)
    );

    always #5 clk = ~clk;

    logic [23:0] blk_size [NODE_COUNT];
    logic [8:0]  blk_link [NODE_COUNT];
    bit          blk_free [NODE_COUNT];
    logic [8:0]  heads [9];
    logic [1:0]  mode_reg;
    bit          debug_reg, protect_reg;
    logic [8:0]  chain_tail [9];

    outcome_t pending_outcomes[$];
    int       failures = 0;
    int       cycles = 0;
    int       gap_pct = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result, actual status %0d", $time, status);
                failures++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (status !== exp_o.st || promoted_node !== exp_o.node ||
                    source_bin !== exp_o.src || target_bin !== exp_o.tgt ||
                    required_bytes !== exp_o.req)
                begin
                    $display("%0t: mismatch expected st=%0d node=%0d src=%0d tgt=%0d req=%0d",
                             $time, exp_o.st, exp_o.node, exp_o.src, exp_o.tgt, exp_o.req);
                    $display("%0t:          actual   st=%0d node=%0d src=%0d tgt=%0d req=%0d",
                             $time, status, promoted_node, source_bin, target_bin,
                             required_bytes);
                    failures++;
                end
            end
        end
    end

    function automatic int size_bin(logic [31:0] s);
        return (s >> 5) < 8 ? int'(s >> 5) : 8;
    endfunction

    function automatic bit well_formed(int n);
        return blk_free[n] && blk_size[n][2:0] == 3'd0 && blk_size[n] >= 24'd16;
    endfunction

    function automatic bit walk_bin_list(int b, logic [31:0] need, output int hit,
                                         output int hit_prev);
        int          cur, prev, steps;
        logic [31:0] best, tol, rem;
        cur = heads[b];
        prev = NODE_COUNT;
        best = 32'h7FFF_FFFF;
        tol = 16;
        steps = 0;
        hit = NODE_COUNT;
        hit_prev = NODE_COUNT;
        while (cur < NODE_COUNT)
        begin
            if (steps >= NODE_COUNT || !well_formed(cur) || size_bin(blk_size[cur]) != b)
            begin
                hit = NODE_COUNT;
                return 1'b0;
            end
            if (blk_size[cur] >= need)
            begin
                rem = blk_size[cur] - need;
                if (rem < best)
                begin
                    hit = cur;
                    hit_prev = prev;
                    best = rem;
                    if (rem < tol)
                        break;
                    tol += 4;
                end
            end
            prev = cur;
            cur = blk_link[cur];
            steps++;
        end
        return 1'b1;
    endfunction

    function automatic outcome_t serve_request(logic [15:0] asked);
        outcome_t    o;
        logic [31:0] need;
        int          tgt, hd, hit, hit_prev;
        o = '{st: ST_BYPASS, node: NONE_CODE, src: 4'd0, tgt: 4'd0, req: 16'd0};
        if (asked > SMALL_LIMIT)
            return o;
        need = (32'(asked) + 32'd15 + (debug_reg ? 32'd2 : 32'd0)) & ~32'd7;
        tgt = size_bin(need);
        o.req = need[15:0];
        o.tgt = 4'(tgt);
        if (mode_reg == MODE_OFF || protect_reg)
            return o;
        hd = heads[tgt];
        if (hd >= NODE_COUNT)
            return o;
        if (!well_formed(hd) || size_bin(blk_size[hd]) != tgt)
        begin
            o.st = ST_INVALID;
            return o;
        end
        if (blk_size[hd] >= need || (tgt == 8 && mode_reg == MODE_SEARCH))
            return o;
        if (!walk_bin_list(tgt, need, hit, hit_prev))
        begin
            o.st = ST_INVALID;
            return o;
        end
        if (hit < NODE_COUNT)
        begin
            o.st = ST_FIT;
            return o;
        end
        for (int b = tgt + 1; b < 9; b++)
        begin
            if (heads[b] >= NODE_COUNT)
                continue;
            if (!walk_bin_list(b, need, hit, hit_prev))
            begin
                o.st = ST_INVALID;
                return o;
            end
            if (hit >= NODE_COUNT)
                continue;
            if (hit_prev >= NODE_COUNT)
                heads[b] = blk_link[hit];
            else
                blk_link[hit_prev] = blk_link[hit];
            blk_link[hit] = heads[tgt];
            heads[tgt] = 9'(hit);
            o.st = ST_PROMOTED;
            o.node = 9'(hit);
            o.src = 4'(b);
            return o;
        end
        o.st = ST_NOFIT;
        return o;
    endfunction

    function automatic outcome_t apply_beat(beat_t b);
        outcome_t o;
        o = '{st: ST_ACK, node: NONE_CODE, src: 4'd0, tgt: 4'd0, req: 16'd0};
        case (b.cmd)
            CMD_NODE:
            begin
                blk_size[b.idx] = b.size;
                blk_link[b.idx] = b.link;
                blk_free[b.idx] = b.free;
            end
            CMD_HEAD:
                if (b.bin < 9)
                    heads[b.bin] = b.head;
            CMD_REQ:
                o = serve_request(b.reqb);
            default:
                o.st = ST_INVALID;
        endcase
        return o;
    endfunction

    task automatic send_beat(beat_t b, bit typed, outcome_t want);
        outcome_t o;
        @(negedge clk);
        start <= 1'b1;
        command <= b.cmd;
        node_index <= b.idx;
        node_size <= b.size;
        node_link <= b.link;
        node_free <= b.free;
        bin_number <= b.bin;
        head_index <= b.head;
        requested_bytes <= b.reqb;
        do
            @(posedge clk);
        while (busy);
        o = apply_beat(b);
        pending_outcomes.push_back(typed ? want : o);
        if ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:    mode_reg = val;
            CFG_DEBUG:   debug_reg = val[0];
            CFG_PROTECT: protect_reg = val[0];
            default:     ;
        endcase
    endtask

    function automatic beat_t noise_beat();
        beat_t b;
        b = beat_t'({$urandom, $urandom, $urandom});
        return b;
    endfunction

    function automatic row_t mk(beat_t b);
        row_t r;
        r.is_cfg = 1'b0;
        r.cfg_idx = '0;
        r.cfg_val = '0;
        r.b = b;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t node_row(int idx, int size, int link, bit free);
        beat_t b;
        b = noise_beat();
        b.cmd = CMD_NODE;
        b.idx = 8'(idx);
        b.size = 24'(size);
        b.link = 9'(link);
        b.free = free;
        return mk(b);
    endfunction

    function automatic row_t head_row(int bin, int head);
        beat_t b;
        b = noise_beat();
        b.cmd = CMD_HEAD;
        b.bin = 4'(bin);
        b.head = 9'(head);
        return mk(b);
    endfunction

    function automatic row_t req_row(int n);
        beat_t b;
        b = noise_beat();
        b.cmd = CMD_REQ;
        b.reqb = 16'(n);
        return mk(b);
    endfunction

    function automatic row_t cfg_row(logic [1:0] idx, logic [1:0] val);
        row_t r;
        r = mk('0);
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic row_t typed_row(row_t r, status_t st, int tgt, int req);
        r.typed = 1'b1;
        r.want = '{st: st, node: NONE_CODE, src: 4'd0, tgt: 4'(tgt), req: 16'(req)};
        return r;
    endfunction

    task automatic random_beat(output beat_t b);
        int sel, bn;
        b = noise_beat();
        sel = $urandom_range(99);
        bn = $urandom_range(0, 8);
        if (sel < 40)
        begin
            b.cmd = CMD_NODE;
            if (bn == 0)
                b.size = 24'(16 + 8 * $urandom_range(0, 1));
            else if (bn == 8)
                b.size = 24'(256 + 8 * $urandom_range(0, 40));
            else
                b.size = 24'(bn * 32 + 8 * $urandom_range(0, 3));
            b.link = chain_tail[bn];
            b.free = $urandom_range(99) < 95;
            if ($urandom_range(99) < 5)
                b.size = 24'($urandom);
            if ($urandom_range(99) < 3)
                b.link = 9'($urandom_range(257, 511));
            chain_tail[bn] = {1'b0, b.idx};
        end
        else if (sel < 55)
        begin
            b.cmd = CMD_HEAD;
            b.bin = 4'(bn);
            b.head = ($urandom_range(9) == 0) ? NONE_CODE : chain_tail[bn];
            if ($urandom_range(99) < 4)
                b.head = 9'($urandom);
        end
        else if (sel < 95)
        begin
            b.cmd = CMD_REQ;
            b.reqb = ($urandom_range(99) < 5) ? 16'($urandom) : 16'($urandom_range(0, 290));
        end
        else if (sel < 98)
            b.cmd = CMD_BAD;
        else
        begin
            b.cmd = CMD_HEAD;
            b.bin = 4'($urandom_range(9, 15));
        end
    endtask

    initial
    begin
        row_t        table_rows[$];
        beat_t       b;
        int          phase_mode[6]  = '{1, 2, 3, 1, 2, 0};
        int          phase_debug[6] = '{0, 1, 0, 1, 0, 1};
        int          phase_prot[6]  = '{0, 0, 0, 0, 1, 0};
        int          phase_gap[6]   = '{0, 58, 33, 0, 58, 33};
        int          phase_len[6]   = '{360, 360, 300, 300, 80, 60};

        for (int i = 0; i < NODE_COUNT; i++)
            blk_size[i] = '0;
        foreach (heads[i])
        begin
            heads[i] = NONE_CODE;
            chain_tail[i] = NONE_CODE;
        end
        mode_reg = MODE_OFF;
        debug_reg = 1'b0;
        protect_reg = 1'b0;

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // Every node is written first so that no walk ever reaches an unwritten slot.
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            row_t r;
            r = node_row(i, (i % 9) * 32 + 16, NONE_CODE, 1'b1);
            send_beat(r.b, 1'b0, '0);
        end

        table_rows.push_back(typed_row(req_row(0), ST_BYPASS, 0, 8));
        table_rows.push_back(typed_row(req_row(65535), ST_BYPASS, 0, 0));
        table_rows.push_back(typed_row(req_row(65147), ST_BYPASS, 8, 65160));
        table_rows.push_back(typed_row(mk('{cmd: CMD_BAD, default: '1}), ST_INVALID, 0, 0));
        table_rows.push_back(typed_row(node_row(255, 24'hFFFFFF, 511, 1'b1), ST_ACK, 0, 0));
        table_rows.push_back(typed_row(head_row(15, 0), ST_ACK, 0, 0));
        table_rows.push_back(cfg_row(CFG_MODE, MODE_SEARCH));
        table_rows.push_back(req_row(40));
        table_rows.push_back(node_row(1, 40, 10, 1'b1));
        table_rows.push_back(node_row(10, 56, NONE_CODE, 1'b1));
        table_rows.push_back(head_row(1, 1));
        table_rows.push_back(req_row(40));
        table_rows.push_back(node_row(2, 64, NONE_CODE, 1'b1));
        table_rows.push_back(head_row(2, 2));
        table_rows.push_back(head_row(4, 4));
        table_rows.push_back(req_row(60));
        table_rows.push_back(req_row(60));
        table_rows.push_back(head_row(8, 8));
        table_rows.push_back(req_row(300));
        table_rows.push_back(cfg_row(CFG_MODE, MODE_COALESCE));
        table_rows.push_back(cfg_row(CFG_DEBUG, 2'd1));
        table_rows.push_back(req_row(300));
        table_rows.push_back(node_row(3, 96, NONE_CODE, 1'b0));
        table_rows.push_back(head_row(3, 3));
        table_rows.push_back(req_row(80));
        table_rows.push_back(cfg_row(CFG_PROTECT, 2'd1));
        table_rows.push_back(req_row(10));
        table_rows.push_back(cfg_row(CFG_PROTECT, 2'd0));

        foreach (table_rows[i])
        begin
            if (table_rows[i].is_cfg)
                write_reg(table_rows[i].cfg_idx, table_rows[i].cfg_val);
            else
                send_beat(table_rows[i].b, table_rows[i].typed, table_rows[i].want);
        end

        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_MODE, 2'(phase_mode[p]));
            write_reg(CFG_DEBUG, 2'(phase_debug[p]));
            write_reg(CFG_PROTECT, 2'(phase_prot[p]));
            gap_pct = phase_gap[p];
            for (int k = 0; k < phase_len[p]; k++)
            begin
                random_beat(b);
                send_beat(b, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
